// ===== design/cssfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cssfp_pkg
// Shared types and constants for the sensor frame parser: header bytes,
// body layout and the parse phase encoding.
// ----------------------------------------------------------------------------
package cssfp_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  // body: channel, status, temp0..temp3, checksum
  localparam int BODY_LEN  = 7;
  localparam int BIDX_W    = 3;
  localparam int DATA_LEN  = BODY_LEN - 1;
  localparam logic [BIDX_W-1:0] CHECK_IDX = BIDX_W'(BODY_LEN - 1);

  localparam int BYTE_CHAN   = 0;
  localparam int BYTE_STATUS = 1;
  localparam int BYTE_TEMP0  = 2;

  localparam int CTRL_W = 3;
  localparam logic [CTRL_W-1:0] CTRL_RESET = 3'd2;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SYNC = 2'd1,
    PH_BODY = 2'd2
  } parse_phase_t;

  typedef logic [7:0] byte_t;

endpackage

// ===== design/checksummed_sensor_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksummed_sensor_frame_parser
// Byte-stream parser for AA 55 framed sensor packets with an 8-bit additive
// checksum, keeping per-channel status, temperature, count and timestamp.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one received byte per beat
//   with the current millisecond tick. Output channel (out_valid / out_stall)
//   carries one result beat per completed frame (header plus seven bytes).
//   Throughput: one byte per cycle. The running checksum is added as body
//   bytes arrive, so the closing checksum byte needs only one compare, a
//   channel range check and a 32-bit count increment before the result
//   register.
//   The result shows in the cycle after the checksum byte is taken.
//   When the receiver stalls, the result register holds; header and body
//   bytes still flow, and only a checksum byte is held off (in_stall) while
//   the previous result is still waiting.
//   cfg_wr_en / cfg_wr_data write the control channel; write only when idle.
//   Reset (rst, synchronous) returns to the header hunt, clears all channel
//   registers and sets the control channel to 2. No clearing pass is needed.
// ----------------------------------------------------------------------------
module checksummed_sensor_frame_parser
  import cssfp_pkg::*;
#(
  parameter int NUM_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CTRL_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       time_now,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              checksum_ok,
  output logic [7:0]        channel_id,
  output logic [7:0]        sensor_status,
  output logic [31:0]       temp_bits,
  output logic              channel_stored,
  output logic              temp_updated,
  output logic [31:0]       update_count,
  output logic              control_update
);

  localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [CTRL_W-1:0] control_channel;
  parse_phase_t      phase, phase_next;
  logic [BIDX_W-1:0] byte_index, byte_index_next;
  byte_t             frame_bytes [DATA_LEN];
  byte_t             sum;

  byte_t             channel_status [NUM_CHANNELS];
  logic [31:0]       channel_temp   [NUM_CHANNELS];
  logic [31:0]       channel_count  [NUM_CHANNELS];
  logic [31:0]       channel_stamp  [NUM_CHANNELS];

  logic              in_acc;
  logic              frame_done;
  logic              out_valid_next;

  byte_t             ch, st, ch_minus;
  logic [31:0]       temp;
  logic              ok, in_range, stored, updated, ctrl;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       count_cur, count_inc, count_out;

  assign in_stall = out_valid && out_stall && (phase == PH_BODY) &&
                    (byte_index == CHECK_IDX);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    frame_done      = 1'b0;
    if (in_acc) begin
      unique case (phase)
        PH_HUNT: begin
          phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
        end
        PH_SYNC: begin
          if (rx_byte == SYNC_SECOND) begin
            phase_next      = PH_BODY;
            byte_index_next = '0;
          end else if (rx_byte != SYNC_FIRST) begin
            phase_next = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (byte_index == CHECK_IDX) begin
            phase_next      = PH_HUNT;
            byte_index_next = '0;
            frame_done      = 1'b1;
          end else begin
            byte_index_next = byte_index + BIDX_W'(1);
          end
        end
        default: begin
          phase_next = (rx_byte == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_index <= '0;
    end else begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
    end
  end

  // body capture and running checksum
  always_ff @(posedge clk) begin
    if (in_acc && phase == PH_SYNC && rx_byte == SYNC_SECOND) begin
      sum <= '0;
    end else if (in_acc && phase == PH_BODY && byte_index != CHECK_IDX) begin
      sum                     <= sum + rx_byte;
      frame_bytes[byte_index] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_channel <= CTRL_RESET;
    end else if (cfg_wr_en) begin
      control_channel <= cfg_wr_data;
    end
  end

  // frame evaluation on the checksum byte
  always_comb begin
    ch        = frame_bytes[BYTE_CHAN];
    st        = frame_bytes[BYTE_STATUS];
    temp      = {frame_bytes[BYTE_TEMP0+3], frame_bytes[BYTE_TEMP0+2],
                 frame_bytes[BYTE_TEMP0+1], frame_bytes[BYTE_TEMP0]};
    ok        = (sum == rx_byte);
    in_range  = (ch != 8'd0) && (ch <= 8'(NUM_CHANNELS));
    ch_minus  = ch - 8'd1;
    slot      = ch_minus[SLOT_W-1:0];
    count_cur = in_range ? channel_count[slot] : '0;
    count_inc = count_cur + 32'd1;
    stored    = ok && in_range;
    updated   = stored && (st == 8'd0);
    ctrl      = updated && (ch == 8'(control_channel));
    count_out = !stored ? '0 : (updated ? count_inc : count_cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        channel_status[i] <= '0;
        channel_temp[i]   <= '0;
        channel_count[i]  <= '0;
        channel_stamp[i]  <= '0;
      end
    end else if (frame_done && stored) begin
      channel_status[slot] <= st;
      if (updated) begin
        channel_temp[slot]  <= temp;
        channel_count[slot] <= count_inc;
        channel_stamp[slot] <= time_now;
      end
    end
  end

  // result register
  assign out_valid_next = frame_done || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      checksum_ok    <= ok;
      channel_id     <= ch;
      sensor_status  <= st;
      temp_bits      <= temp;
      channel_stored <= stored;
      temp_updated   <= updated;
      update_count   <= count_out;
      control_update <= ctrl;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  a_result_from_frame: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall && phase == PH_BODY))
    else $error("result without a completed frame");

  a_flag_chain: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!control_update || temp_updated) &&
                  (!temp_updated || channel_stored) &&
                  (!channel_stored || checksum_ok))
    else $error("result flags inconsistent");

  a_count_zero_unstored: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !channel_stored) |-> (update_count == 32'd0))
    else $error("nonzero count on unstored frame");

  a_index_in_body: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_BODY) |-> (byte_index == '0))
    else $error("byte index left over outside frame body");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for checksummed_sensor_frame_parser. A queue of byte
// beats (directed frames, then mostly well-formed random frames mixed with
// broken headers and line noise) feeds a clocked driver. The driver also
// runs a byte-level model of the parser and queues the expected frame result
// for every accepted byte that completes a frame. A clocked monitor checks
// each output beat field by field. Both sides idle at random, except in the last two phases; the control
// channel is rewritten between phases, including values that match no
// channel.
// ----------------------------------------------------------------------------
module testbench;
  import cssfp_pkg::*;

  localparam int NUM_CHAN     = 4;
  localparam int BEATS_PER_PH = 140;
  localparam int SETTLE_CYC   = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 100;

  typedef struct {
    byte_t       data;
    logic [31:0] tick;
  } rx_beat_t;

  typedef struct {
    logic        ok;
    byte_t       chan;
    byte_t       stat;
    logic [31:0] temp;
    logic        stored;
    logic        updated;
    logic [31:0] count;
    logic        ctrl;
  } frame_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CTRL_W-1:0] cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        rx_byte;
  logic [31:0]       time_now;
  logic              out_valid;
  logic              out_stall;
  logic              checksum_ok;
  logic [7:0]        channel_id;
  logic [7:0]        sensor_status;
  logic [31:0]       temp_bits;
  logic              channel_stored;
  logic              temp_updated;
  logic [31:0]       update_count;
  logic              control_update;

  rx_beat_t      beat_q[$];
  frame_result_t expected_frames[$];
  int            beats_queued = 0;
  int            error_count  = 0;
  int            cycle_count  = 0;
  int            send_idle_pct;
  int            recv_stall_pct;

  // parser model state
  parse_phase_t      phase_m;
  int                idx_m;
  byte_t             body_m [BODY_LEN];
  logic [CTRL_W-1:0] ctrl_chan_m;
  byte_t             status_m [1:NUM_CHAN];
  logic [31:0]       temp_m [1:NUM_CHAN];
  logic [31:0]       count_m [1:NUM_CHAN];
  logic [31:0]       stamp_m [1:NUM_CHAN];

  checksummed_sensor_frame_parser #(
    .NUM_CHANNELS(NUM_CHAN)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .time_now      (time_now),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .checksum_ok   (checksum_ok),
    .channel_id    (channel_id),
    .sensor_status (sensor_status),
    .temp_bits     (temp_bits),
    .channel_stored(channel_stored),
    .temp_updated  (temp_updated),
    .update_count  (update_count),
    .control_update(control_update)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** checksummed_sensor_frame_parser: FAILED **");
      $finish;
    end
  end

  task automatic flag_error(input string msg);
    if (error_count < PRINT_CAP) $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic push_beat(input byte_t data);
    rx_beat_t b;
    b.data = data;
    b.tick = $urandom;
    beat_q.push_back(b);
    beats_queued++;
  endtask

  task automatic push_frame(input byte_t chan, input byte_t stat, input logic [31:0] temp,
                            input bit good_sum, input bit double_sync);
    byte_t sum;
    sum = chan + stat + temp[7:0] + temp[15:8] + temp[23:16] + temp[31:24];
    if (!good_sum) sum = sum + byte_t'($urandom_range(1, 255));
    push_beat(SYNC_FIRST);
    if (double_sync) push_beat(SYNC_FIRST);
    push_beat(SYNC_SECOND);
    push_beat(chan);
    push_beat(stat);
    push_beat(temp[7:0]);
    push_beat(temp[15:8]);
    push_beat(temp[23:16]);
    push_beat(temp[31:24]);
    push_beat(sum);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (beat_q.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_control_channel(input logic [CTRL_W-1:0] chan);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= chan;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    ctrl_chan_m = chan;
  endtask

  // driver + parser model: predicts on each accepted beat
  always @(posedge clk) begin : driver
    rx_beat_t      nxt;
    frame_result_t res;
    byte_t         csum;
    int            i;
    if (rst) begin
      in_valid <= 1'b0;
      phase_m  = PH_HUNT;
      idx_m    = 0;
      for (i = 1; i <= NUM_CHAN; i++) begin
        status_m[i] = '0;
        temp_m[i]   = '0;
        count_m[i]  = '0;
        stamp_m[i]  = '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        case (phase_m)
          PH_SYNC: begin
            if (rx_byte == SYNC_SECOND) begin
              phase_m = PH_BODY;
              idx_m   = 0;
            end else if (rx_byte != SYNC_FIRST) begin
              phase_m = PH_HUNT;
            end
          end
          PH_BODY: begin
            body_m[idx_m] = rx_byte;
            idx_m++;
            if (idx_m == BODY_LEN) begin
              phase_m = PH_HUNT;
              idx_m   = 0;
              csum    = '0;
              for (i = 0; i < DATA_LEN; i++) csum = csum + body_m[i];
              res.ok      = (csum == body_m[DATA_LEN]);
              res.chan    = body_m[BYTE_CHAN];
              res.stat    = body_m[BYTE_STATUS];
              res.temp    = {body_m[BYTE_TEMP0+3], body_m[BYTE_TEMP0+2],
                             body_m[BYTE_TEMP0+1], body_m[BYTE_TEMP0]};
              res.stored  = 1'b0;
              res.updated = 1'b0;
              res.count   = '0;
              res.ctrl    = 1'b0;
              if (res.ok && res.chan >= 1 && res.chan <= NUM_CHAN) begin
                res.stored = 1'b1;
                status_m[res.chan] = res.stat;
                if (res.stat == 8'd0) begin
                  res.updated = 1'b1;
                  temp_m[res.chan]  = res.temp;
                  count_m[res.chan] = count_m[res.chan] + 32'd1;
                  stamp_m[res.chan] = time_now;
                  res.ctrl = (res.chan == {5'd0, ctrl_chan_m});
                end
                res.count = count_m[res.chan];
              end
              expected_frames.push_back(res);
            end
          end
          default: phase_m = (rx_byte == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
        endcase
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = beat_q.pop_front();
          in_valid <= 1'b1;
          rx_byte  <= nxt.data;
          time_now <= nxt.tick;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_frames.size() == 0) begin
          flag_error("result beat with no frame expected");
        end else begin
          want = expected_frames.pop_front();
          check_field("checksum_ok",    32'(checksum_ok),    32'(want.ok));
          check_field("channel_id",     32'(channel_id),     32'(want.chan));
          check_field("sensor_status",  32'(sensor_status),  32'(want.stat));
          check_field("temp_bits",      temp_bits,           want.temp);
          check_field("channel_stored", 32'(channel_stored), 32'(want.stored));
          check_field("temp_updated",   32'(temp_updated),   32'(want.updated));
          check_field("update_count",   update_count,        want.count);
          check_field("control_update", 32'(control_update), 32'(want.ctrl));
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin : stimulus
    logic [CTRL_W-1:0] ctrl_seq [6];
    int                ph;
    int                pick;
    int                target;
    byte_t             chan;
    byte_t             stat;
    ctrl_seq = '{3'd1, 3'd4, 3'd7, 3'd3, 3'd0, 3'd2};
    rst            = 1'b1;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_valid       = 1'b0;
    rx_byte        = '0;
    time_now       = '0;
    out_stall      = 1'b0;
    ctrl_chan_m    = CTRL_RESET;
    send_idle_pct  = 8;
    recv_stall_pct = 62;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: noise, repeated sync, bad second sync, all-ones temp,
    // nonzero status on the top channel
    push_beat(8'hFF);
    push_frame(8'd2, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_beat(SYNC_FIRST);
    push_beat(8'h00);
    push_frame(8'd4, 8'h80, 32'h0403_0201, 1'b1, 1'b0);
    wait_drained();

    for (ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct  = 8;
        recv_stall_pct = 62;
      end else if (ph < 4) begin
        send_idle_pct  = 62;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      set_control_channel(ctrl_seq[ph]);
      target = beats_queued + BEATS_PER_PH;
      while (beats_queued < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          chan = ($urandom_range(0, 9) < 8) ? byte_t'($urandom_range(1, NUM_CHAN))
                                            : byte_t'($urandom);
          stat = ($urandom_range(0, 9) < 6) ? 8'h00 : byte_t'($urandom);
          push_frame(chan, stat, $urandom, $urandom_range(0, 9) < 8,
                     $urandom_range(0, 7) == 0);
        end else if (pick < 88) begin
          push_beat(SYNC_FIRST);
          push_beat(byte_t'($urandom));
        end else begin
          push_beat(byte_t'($urandom));
        end
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("** checksummed_sensor_frame_parser: PASSED **");
    end else begin
      $display("** checksummed_sensor_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cssfp_pkg.sv
design/checksummed_sensor_frame_parser.sv
tb/sv/testbench.sv
